[src/wbp_pkg.sv]
// wbp_pkg: shared types and constants for the wheel balance pid core
// payload structs, configuration struct, register indexes and reset values
// no dependencies
`timescale 1ns / 1ps

package wbp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPEED_FLOOR    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SPEED_CEILING  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_GLITCH_LIMIT   = 3'd6;

  localparam logic [15:0] RST_GAIN_P         = 16'd256;
  localparam logic [15:0] RST_GAIN_I         = 16'd26;
  localparam logic [15:0] RST_GAIN_D         = 16'd0;
  localparam logic [9:0]  RST_INTEGRAL_LIMIT = 10'd100;
  localparam logic [9:0]  RST_SPEED_FLOOR    = 10'd850;
  localparam logic [9:0]  RST_SPEED_CEILING  = 10'd1023;
  localparam logic [7:0]  RST_GLITCH_LIMIT   = 8'd3;

  typedef struct packed {
    logic [15:0] left_count;
    logic [15:0] right_count;
    logic [9:0]  left_base;
    logic [9:0]  right_base;
    logic        heading;
    logic        straight_on;
  } wbp_in_t;

  typedef struct packed {
    logic [9:0]  left_speed;
    logic [9:0]  right_speed;
    logic        drive_heading;
    logic        apply_drive;
    logic [15:0] left_count_fixed;
  } wbp_out_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [9:0]  integral_limit;
    logic [9:0]  speed_floor;
    logic [9:0]  speed_ceiling;
    logic [7:0]  glitch_limit;
  } wbp_cfg_t;

endpackage

[src/wbp_err_track.sv]
// wbp_err_track: glitch rejection, error, clamped integral and derivative
// holds the controller state and registers the per-tick error terms
// depends on wbp_pkg
`timescale 1ns / 1ps

module wbp_err_track
  import wbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [15:0]        left_count,
  input  logic [15:0]        right_count,
  input  wbp_cfg_t           cfg,
  output logic [15:0]        left_r,
  output logic signed [16:0] err_r,
  output logic signed [10:0] sum_r,
  output logic signed [17:0] der_r
);

  logic [15:0]        acc_left_r;
  logic signed [10:0] err_sum_r;
  logic signed [16:0] prev_err_r;

  logic signed [16:0] jump;
  logic               glitch;
  logic [15:0]        left_nxt;
  logic signed [16:0] err_nxt;
  logic signed [17:0] sum_raw;
  logic signed [17:0] lim_pos;
  logic signed [17:0] lim_neg;
  logic signed [10:0] sum_nxt;
  logic signed [17:0] der_nxt;

  always_comb begin
    jump     = $signed({1'b0, left_count}) - $signed({1'b0, acc_left_r});
    glitch   = jump > $signed({9'd0, cfg.glitch_limit});
    left_nxt = glitch ? acc_left_r : left_count;
    err_nxt  = $signed({1'b0, left_nxt}) - $signed({1'b0, right_count});
    sum_raw  = {{7{err_sum_r[10]}}, err_sum_r} + {err_nxt[16], err_nxt};
    lim_pos  = $signed({8'd0, cfg.integral_limit});
    lim_neg  = -lim_pos;
    if (sum_raw > lim_pos) begin
      sum_nxt = lim_pos[10:0];
    end else if (sum_raw < lim_neg) begin
      sum_nxt = lim_neg[10:0];
    end else begin
      sum_nxt = sum_raw[10:0];
    end
    der_nxt = {err_nxt[16], err_nxt} - {prev_err_r[16], prev_err_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_left_r <= '0;
      err_sum_r  <= '0;
      prev_err_r <= '0;
    end else if (en) begin
      acc_left_r <= left_nxt;
      err_sum_r  <= sum_nxt;
      prev_err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left_r <= left_nxt;
      err_r  <= err_nxt;
      sum_r  <= sum_nxt;
      der_r  <= der_nxt;
    end
  end

endmodule

[src/wheel_balance_pid_core.sv]
// wheel_balance_pid_core: straight-line pid correction for a two-wheeled drive
// input register, error tracking, gain products, sum, rounding and clamping
// depends on wbp_pkg and wbp_err_track
`timescale 1ns / 1ps

// usage
//   in_valid/in_stall/in_data carry one control tick; a transaction takes place
//   at a rising edge with in_valid high and in_stall low
//   out_valid/out_stall/out_data return one result per tick, in order
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the gain, limit and speed
//   registers; cfg_ready is always high, unknown indexes are ignored;
//   write only while no tick is in flight
//   throughput: one tick per cycle while the receiver does not stall, through the five-stage pipeline
//   (input register, error tracking, gain multipliers, sum, round and clamp)
//   reset: controller state cleared, registers take their default values,
//   pipeline emptied
//   when the receiver stalls, empty stages still fill; in_stall rises only
//   once every stage holds a tick

module wheel_balance_pid_core
  import wbp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wbp_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wbp_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  typedef struct packed {
    logic [15:0] left;
    logic [9:0]  left_base;
    logic [9:0]  right_base;
    logic        heading;
    logic        straight_on;
  } wbp_side_t;

  wbp_cfg_t cfg_r;

  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic en0, en1, en2, en3, en4;

  wbp_in_t   in_r;
  wbp_side_t side1, side2_r, side3_r;

  logic [15:0]        left1;
  logic signed [16:0] err1;
  logic signed [10:0] sum1;
  logic signed [17:0] der1;
  logic [9:0]         lb1_r, rb1_r;
  logic               hd1_r, on1_r;

  logic signed [33:0] prod_p_r;
  logic signed [27:0] prod_i_r;
  logic signed [34:0] prod_d_r;
  logic signed [35:0] acc_r;

  logic signed [27:0] quot;
  logic               adj;
  logic signed [28:0] corr;
  logic signed [29:0] ls_raw, rs_raw;
  logic signed [29:0] ceil_s, floor_s;
  logic [9:0]         ls_nxt, rs_nxt;
  wbp_out_t           out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= RST_GAIN_P;
      cfg_r.gain_i         <= RST_GAIN_I;
      cfg_r.gain_d         <= RST_GAIN_D;
      cfg_r.integral_limit <= RST_INTEGRAL_LIMIT;
      cfg_r.speed_floor    <= RST_SPEED_FLOOR;
      cfg_r.speed_ceiling  <= RST_SPEED_CEILING;
      cfg_r.glitch_limit   <= RST_GLITCH_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:         cfg_r.gain_p         <= cfg_data;
        REG_GAIN_I:         cfg_r.gain_i         <= cfg_data;
        REG_GAIN_D:         cfg_r.gain_d         <= cfg_data;
        REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_data[9:0];
        REG_SPEED_FLOOR:    cfg_r.speed_floor    <= cfg_data[9:0];
        REG_SPEED_CEILING:  cfg_r.speed_ceiling  <= cfg_data[9:0];
        REG_GLITCH_LIMIT:   cfg_r.glitch_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // stage enables, empty stages always advance
  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en0) begin
      in_r <= in_data;
    end
  end

  // stage 1: error tracking, state moves only for a real tick
  wbp_err_track u_err_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en1 && v0_r),
    .left_count  (in_r.left_count),
    .right_count (in_r.right_count),
    .cfg         (cfg_r),
    .left_r      (left1),
    .err_r       (err1),
    .sum_r       (sum1),
    .der_r       (der1)
  );

  always_ff @(posedge clk) begin
    if (en1 && v0_r) begin
      lb1_r <= in_r.left_base;
      rb1_r <= in_r.right_base;
      hd1_r <= in_r.heading;
      on1_r <= in_r.straight_on;
    end
  end

  assign side1 = '{left: left1, left_base: lb1_r, right_base: rb1_r,
                   heading: hd1_r, straight_on: on1_r};

  // stage 2: gain products
  always_ff @(posedge clk) begin
    if (en2) begin
      prod_p_r <= 34'($signed({1'b0, cfg_r.gain_p})) * 34'(err1);
      prod_i_r <= 28'($signed({1'b0, cfg_r.gain_i})) * 28'(sum1);
      prod_d_r <= 35'($signed({1'b0, cfg_r.gain_d})) * 35'(der1);
      side2_r  <= side1;
    end
  end

  // stage 3: sum of terms
  always_ff @(posedge clk) begin
    if (en3) begin
      acc_r   <= {{2{prod_p_r[33]}}, prod_p_r} + {{8{prod_i_r[27]}}, prod_i_r}
               + {prod_d_r[34], prod_d_r};
      side3_r <= side2_r;
    end
  end

  // stage 4: divide by 256 toward zero, apply and clamp
  always_comb begin
    quot    = acc_r[35:8];
    adj     = acc_r[35] && (acc_r[7:0] != 8'd0);
    corr    = {quot[27], quot} + 29'(adj);
    ls_raw  = $signed({20'd0, side3_r.left_base}) - {corr[28], corr};
    rs_raw  = $signed({20'd0, side3_r.right_base}) + {corr[28], corr};
    ceil_s  = $signed({20'd0, cfg_r.speed_ceiling});
    floor_s = $signed({20'd0, cfg_r.speed_floor});
    if (ls_raw > ceil_s) begin
      ls_nxt = cfg_r.speed_ceiling;
    end else if (ls_raw < floor_s) begin
      ls_nxt = cfg_r.speed_floor;
    end else begin
      ls_nxt = ls_raw[9:0];
    end
    if (rs_raw > ceil_s) begin
      rs_nxt = cfg_r.speed_ceiling;
    end else if (rs_raw < floor_s) begin
      rs_nxt = cfg_r.speed_floor;
    end else begin
      rs_nxt = rs_raw[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_r.left_speed       <= ls_nxt;
      out_r.right_speed      <= rs_nxt;
      out_r.drive_heading    <= side3_r.heading;
      out_r.apply_drive      <= side3_r.straight_on;
      out_r.left_count_fixed <= side3_r.left;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

[tb/tb_wheel_balance_pid_core.sv]
`timescale 1ns / 1ps
// tb_wheel_balance_pid_core: self-checking regression for the wheel balance pid core
// drives control ticks and register writes, predicts every result in-bench, checks in order
// depends on wbp_pkg and wheel_balance_pid_core

module tb_wheel_balance_pid_core;
  import wbp_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned PHASE_TICKS  = 155;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned QUIET_LIMIT  = 5000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  wbp_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wbp_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // shadow registers and controller state
  wbp_cfg_t ctrl_cfg = '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
                         integral_limit: RST_INTEGRAL_LIMIT, speed_floor: RST_SPEED_FLOOR,
                         speed_ceiling: RST_SPEED_CEILING, glitch_limit: RST_GLITCH_LIMIT};
  logic [15:0] held_left = '0;
  int          err_sum   = 0;
  int          last_err  = 0;

  wbp_in_t     tick_q[$];
  int unsigned gap_q[$];
  wbp_out_t    expected_drive_q[$];

  int unsigned ticks_issued  = 0;
  int unsigned ticks_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned reg_writes    = 0;
  int unsigned settings_run  = 1;
  int unsigned stall_left    = 0;
  int unsigned quiet_cycles  = 0;
  int          walk          = 0;

  wheel_balance_pid_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [9:0] clamp_duty(longint v);
    if (v > longint'(ctrl_cfg.speed_ceiling)) return ctrl_cfg.speed_ceiling;
    if (v < longint'(ctrl_cfg.speed_floor)) return ctrl_cfg.speed_floor;
    return v[9:0];
  endfunction

  function automatic wbp_out_t balance_step(wbp_in_t t);
    wbp_out_t    r;
    logic [15:0] left;
    int          jump;
    int          err;
    int          lim;
    int          sum;
    longint      mix;
    longint      corr;
    jump = int'(t.left_count) - int'(held_left);
    if (jump > int'(ctrl_cfg.glitch_limit)) begin
      left = held_left;
    end else begin
      held_left = t.left_count;
      left = t.left_count;
    end
    err = int'(left) - int'(t.right_count);
    lim = int'(ctrl_cfg.integral_limit);
    sum = err_sum + err;
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    err_sum = sum;
    mix = longint'(ctrl_cfg.gain_p) * longint'(err)
        + longint'(ctrl_cfg.gain_i) * longint'(err_sum)
        + longint'(ctrl_cfg.gain_d) * longint'(err - last_err);
    corr = mix / 256;
    r.left_speed       = clamp_duty(longint'(t.left_base) - corr);
    r.right_speed      = clamp_duty(longint'(t.right_base) + corr);
    r.drive_heading    = t.heading;
    r.apply_drive      = t.straight_on;
    r.left_count_fixed = left;
    last_err = err;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_GAIN_P:         ctrl_cfg.gain_p = val;
      REG_GAIN_I:         ctrl_cfg.gain_i = val;
      REG_GAIN_D:         ctrl_cfg.gain_d = val;
      REG_INTEGRAL_LIMIT: ctrl_cfg.integral_limit = val[9:0];
      REG_SPEED_FLOOR:    ctrl_cfg.speed_floor = val[9:0];
      REG_SPEED_CEILING:  ctrl_cfg.speed_ceiling = val[9:0];
      REG_GLITCH_LIMIT:   ctrl_cfg.glitch_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                           logic [15:0] lim, logic [15:0] flo, logic [15:0] ceil,
                           logic [15:0] glim);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_INTEGRAL_LIMIT, lim);
    write_reg(REG_SPEED_FLOOR, flo);
    write_reg(REG_SPEED_CEILING, ceil);
    write_reg(REG_GLITCH_LIMIT, glim);
    settings_run++;
  endtask

  // wait until every queued tick has come back checked
  task automatic settle();
    while (tick_q.size() != 0 || ticks_issued != ticks_checked) @(posedge clk);
  endtask

  task automatic add_tick(logic [15:0] lc, logic [15:0] rc, logic [9:0] lb, logic [9:0] rb,
                          logic hd, logic en, int unsigned gap);
    wbp_in_t t;
    t.left_count  = lc;
    t.right_count = rc;
    t.left_base   = lb;
    t.right_base  = rb;
    t.heading     = hd;
    t.straight_on = en;
    gap_q.push_back(gap);
    tick_q.push_back(t);
  endtask

  // mostly a slowly advancing encoder walk, with spikes, reversals and noise mixed in
  task automatic add_random_ticks(int unsigned count, int unsigned glim, int unsigned spread);
    int unsigned kind;
    int unsigned gap;
    int          lc;
    int          rc;
    for (int unsigned i = 0; i < count; i++) begin
      gap = ((i / 40) % 2 == 0) ? 0 : $urandom_range(0, 3);
      kind = $urandom_range(0, 99);
      rc = -1;
      if (kind < 75) begin
        walk = walk + int'($urandom_range(0, glim));
        if (walk > 65535) walk = 0;
        lc = walk;
      end else if (kind < 83) begin
        lc = walk + int'(glim) + 1 + int'($urandom_range(0, 400));
        if (lc > 65535) lc = 65535;
      end else if (kind < 90) begin
        walk = int'($urandom_range(0, walk));
        lc = walk;
      end else begin
        lc = int'($urandom_range(0, 65535));
        rc = int'($urandom_range(0, 65535));
        walk = 0;
      end
      if (rc < 0) begin
        rc = walk + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (rc < 0) rc = 0;
        if (rc > 65535) rc = 65535;
      end
      add_tick(16'(lc), 16'(rc), 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
    end
  endtask

  // transaction driver
  always @(posedge clk) begin
    logic free;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      free = !in_valid;
      if (in_valid && !in_stall) begin
        expected_drive_q.push_back(balance_step(in_data));
        free = 1'b1;
      end
      if (free) begin
        if (tick_q.size() != 0 && gap_q[0] == 0) begin
          in_data <= tick_q.pop_front();
          void'(gap_q.pop_front());
          in_valid <= 1'b1;
          ticks_issued++;
        end else begin
          if (tick_q.size() != 0) gap_q[0] = gap_q[0] - 1;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    wbp_out_t    want;
    int unsigned hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid && !out_stall) begin
        if (expected_drive_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_drive_q.pop_front();
          check_field("left_speed", 32'(want.left_speed), 32'(out_data.left_speed));
          check_field("right_speed", 32'(want.right_speed), 32'(out_data.right_speed));
          check_field("drive_heading", 32'(want.drive_heading),
                      32'(out_data.drive_heading));
          check_field("apply_drive", 32'(want.apply_drive), 32'(out_data.apply_drive));
          check_field("left_count_fixed", 32'(want.left_count_fixed),
                      32'(out_data.left_count_fixed));
          ticks_checked++;
          hold = ((ticks_checked / 64) % 3 == 0) ? 0 : $urandom_range(0, 3);
          // long back-pressure so the pipeline fills and stalls its input
          if (ticks_checked == 200 || ticks_checked == 650) hold = HOLD_CYCLES;
        end
      end
      if (hold > 0) begin
        out_stall  <= 1'b1;
        stall_left <= hold - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("wheel_balance_pid_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: glitch edge, reversal, clamps, correction disabled
    add_tick(16'd0, 16'd0, 10'd0, 10'd0, 1'b0, 1'b0, 0);
    add_tick(16'd3, 16'd0, 10'd1023, 10'd1023, 1'b1, 1'b1, 0);
    add_tick(16'd65535, 16'd65535, 10'd512, 10'd512, 1'b1, 1'b0, 2);
    add_tick(16'd1, 16'd65535, 10'd900, 10'd900, 1'b0, 1'b1, 0);
    add_tick(16'd5, 16'd1, 10'd1000, 10'd860, 1'b1, 1'b1, 1);
    add_tick(16'd4, 16'd0, 10'd950, 10'd950, 1'b0, 1'b0, 0);
    add_tick(16'd4, 16'd200, 10'd1023, 10'd0, 1'b1, 1'b1, 0);
    add_tick(16'h5555, 16'hAAAA, 10'h155, 10'h2AA, 1'b0, 1'b1, 3);
    add_tick(16'd2, 16'hFFFF, 10'h2AA, 10'h155, 1'b1, 1'b0, 0);
    add_tick(16'd5, 16'd5, 10'd851, 10'd849, 1'b1, 1'b1, 0);
    walk = 5;
    add_random_ticks(PHASE_TICKS, 32'(RST_GLITCH_LIMIT), 40);
    settle();

    load_regs(16'd512, 16'd64, 16'd300, 16'd200, 16'd0, 16'd1023, 16'd10);
    write_reg(REG_UNUSED, 16'hFFFF);
    add_random_ticks(PHASE_TICKS, 10, 150);
    settle();

    // largest values; narrow registers see their upper bits dropped
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    add_tick(16'd0, 16'd65535, 10'd0, 10'd1023, 1'b1, 1'b1, 0);
    add_tick(16'd255, 16'd0, 10'd1023, 10'd0, 1'b0, 1'b1, 0);
    add_tick(16'd511, 16'd65535, 10'd511, 10'd511, 1'b1, 1'b0, 1);
    add_tick(16'd65535, 16'd0, 10'd0, 10'd0, 1'b0, 1'b1, 0);
    walk = 255;
    add_random_ticks(PHASE_TICKS, 255, 3000);
    settle();

    // zero gains and limits, floor above ceiling
    load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1023, 16'd0, 16'd0);
    add_random_ticks(PHASE_TICKS, 0, 20);
    settle();

    load_regs(16'd300, 16'd1000, 16'd40, 16'd512, 16'd700, 16'd300, 16'd7);
    add_random_ticks(PHASE_TICKS, 7, 60);
    settle();

    load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    add_random_ticks(PHASE_TICKS, 32'(ctrl_cfg.glitch_limit), 200);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d control ticks over %0d register settings, %0d register writes",
             ticks_checked, settings_run, reg_writes);
    $display("covered glitch rejection, count reversal, integral clamp and inverted speed range");
    if (mismatches == 0 && expected_drive_q.size() == 0) begin
      $display("wheel_balance_pid_core regression: pass");
    end else begin
      $display("wheel_balance_pid_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/wbp_pkg.sv
src/wbp_err_track.sv
src/wheel_balance_pid_core.sv
tb/tb_wheel_balance_pid_core.sv
